// ===== rtl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
package b2da_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned STEPS    = 8;    // double-dabble steps per stage
    localparam int unsigned DD_STAGES = VALUE_W / STEPS;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef logic [DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    typedef struct packed {
        logic                func;
        logic [VALUE_W-1:0]  value;
    } num_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } chr_t;

    // Word carried through the conversion stages.
    typedef struct packed {
        logic               neg;
        bcd_t               bcd;
        logic [VALUE_W-1:0] bin;
    } dd_t;

endpackage

// ===== rtl/binary_to_decimal_ascii_core.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_dd_stage and b2da_serial.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------
//   num     | num_valid / num_ready  | num.func, num.value
//   chr     | chr_valid / chr_ready  | chr.char_code, chr.last
//
// A number passes a sign stage and four conversion stages (eight double-dabble
// steps each) before reaching the serialiser, which loads its state registers
// and then its output register. It sends one character per cycle while chr is
// not stalled, 1 to 11 per number, and loads the next number as a run's last
// character leaves. Reset clears all valid bits and the serialiser.
// A stall on chr holds every stage; nothing is dropped or repeated.
module binary_to_decimal_ascii_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           num_valid,
    output logic           num_ready,
    input  b2da_pkg::num_t num,
    output logic           chr_valid,
    input  logic           chr_ready,
    output b2da_pkg::chr_t chr
);
    import b2da_pkg::*;

    logic s0_valid_reg;
    dd_t  s0_reg;
    dd_t  s0_next;
    logic neg;

    logic [DD_STAGES:0] st_valid;
    logic [DD_STAGES:0] st_ready;
    dd_t                st_data [DD_STAGES+1];

    // sign stage: form the magnitude in unsigned arithmetic
    assign neg = num.func && num.value[VALUE_W-1];

    always_comb
    begin
        s0_next.neg = neg;
        s0_next.bcd = '0;
        s0_next.bin = neg ? (VALUE_W'(0) - num.value) : num.value;
    end

    assign num_ready = !s0_valid_reg || st_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (num_ready)
        begin
            s0_valid_reg <= num_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (num_ready && num_valid)
        begin
            s0_reg <= s0_next;
        end
    end

    assign st_valid[0] = s0_valid_reg;
    assign st_data[0]  = s0_reg;

    for (genvar g = 0; g < DD_STAGES; g++)
    begin : g_dd
        b2da_dd_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[g]),
            .up_ready (st_ready[g]),
            .up       (st_data[g]),
            .dn_valid (st_valid[g+1]),
            .dn_ready (st_ready[g+1]),
            .dn       (st_data[g+1])
        );
    end

    b2da_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (st_valid[DD_STAGES]),
        .up_ready  (st_ready[DD_STAGES]),
        .up        (st_data[DD_STAGES]),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr       (chr)
    );

endmodule

// ===== rtl/b2da_dd_stage.sv =====
// One registered stage of the binary to BCD conversion: eight shift-add-3 steps.
// Depends on b2da_pkg.
module b2da_dd_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  b2da_pkg::dd_t up,
    output logic         dn_valid,
    input  logic         dn_ready,
    output b2da_pkg::dd_t dn
);
    import b2da_pkg::*;

    logic valid_reg;
    dd_t  data_reg;
    dd_t  data_next;
    logic [DIGITS*DIGIT_W+VALUE_W-1:0] work;

    always_comb
    begin
        work = {up.bcd, up.bin};
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (work[VALUE_W + d*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    work[VALUE_W + d*DIGIT_W +: DIGIT_W] =
                        work[VALUE_W + d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            work = work << 1;
        end
        data_next.neg = up.neg;
        data_next.bcd = work[DIGITS*DIGIT_W+VALUE_W-1:VALUE_W];
        data_next.bin = work[VALUE_W-1:0];
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/b2da_serial.sv =====
// Output serialiser: turns one BCD word into a run of ASCII characters.
// Depends on b2da_pkg.
module b2da_serial (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  b2da_pkg::dd_t up,
    output logic          chr_valid,
    input  logic          chr_ready,
    output b2da_pkg::chr_t chr
);
    import b2da_pkg::*;

    logic             busy_reg;
    logic             sign_reg;
    logic [IDX_W-1:0] idx_reg;
    bcd_t             bcd_reg;
    logic             out_valid_reg;
    chr_t             out_reg;

    logic             out_ok;
    logic             fin;
    logic [IDX_W-1:0] top_idx;
    chr_t             cur;

    // highest non-zero digit; a zero value still gives one digit
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (up.bcd[d] != '0)
            begin
                top_idx = IDX_W'(d);
            end
        end
    end

    always_comb
    begin
        cur.last = !sign_reg && (idx_reg == '0);
        if (sign_reg)
        begin
            cur.char_code = ASCII_MINUS;
        end
        else
        begin
            cur.char_code = ASCII_ZERO + {4'b0000, bcd_reg[idx_reg]};
        end
    end

    assign out_ok    = !out_valid_reg || chr_ready;
    assign fin       = busy_reg && out_ok && cur.last;
    assign up_ready  = !busy_reg || fin;
    assign chr_valid = out_valid_reg;
    assign chr       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sign_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ok)
            begin
                out_valid_reg <= busy_reg;
            end
            // a new item may load in the cycle the previous run's last character leaves
            if (up_valid && up_ready)
            begin
                busy_reg <= 1'b1;
                sign_reg <= up.neg;
                idx_reg  <= top_idx;
            end
            else if (busy_reg && out_ok)
            begin
                if (sign_reg)
                begin
                    sign_reg <= 1'b0;
                end
                else if (idx_reg != '0)
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
                if (fin)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ok && busy_reg)
        begin
            out_reg <= cur;
        end
        if (up_valid && up_ready)
        begin
            bcd_reg <= up.bcd;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for binary_to_decimal_ascii_core: numbers in, decimal ASCII runs out.
// Depends on b2da_pkg and the core RTL. A scoreboard class predicts every character run
// and compares each character taken from the core against the oldest prediction.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b2da_pkg::*;

    localparam logic FMT_UNSIGNED = 1'b0;
    localparam logic FMT_SIGNED   = 1'b1;
    localparam int   RANDOM_NUMBERS = 300;
    localparam int   IDLE_PCT       = 29;
    localparam int   STALL_LIMIT    = 2000;
    localparam int   DRAIN_CYCLES   = 16;

    class chr_scoreboard;
        chr_t        expected_chars[$];
        int unsigned errors;
        int unsigned numbers_taken;
        int unsigned negatives_taken;
        int unsigned chars_checked;

        // Work out the run of characters for one accepted number.
        function void note_number(num_t n);
            logic [VALUE_W-1:0] mag;
            logic [7:0]         dec[DIGITS];
            int                 nd;
            chr_t               c;
            nd = 0;
            numbers_taken++;
            mag = n.value;
            if (n.func == FMT_SIGNED && n.value[VALUE_W-1])
            begin
                negatives_taken++;
                mag = '0 - n.value;
                c.char_code = ASCII_MINUS;
                c.last = 1'b0;
                expected_chars.push_back(c);
            end
            // Collect digits least significant first; zero still yields one digit.
            do
            begin
                dec[nd] = ASCII_ZERO + 8'(mag % 10);
                mag = mag / 10;
                nd++;
            end
            while (mag != 0);
            for (int i = nd - 1; i >= 0; i--)
            begin
                c.char_code = dec[i];
                c.last = (i == 0);
                expected_chars.push_back(c);
            end
        endfunction

        function void check_char(chr_t got);
            chr_t want;
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected character: expected none, got %02h last %0b",
                         $time, got.char_code, got.last);
                return;
            end
            want = expected_chars.pop_front();
            if (got.char_code !== want.char_code)
            begin
                errors++;
                $display("%0t: char_code: expected %02h, got %02h",
                         $time, want.char_code, got.char_code);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: last: expected %0b, got %0b", $time, want.last, got.last);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic num_valid = 1'b0;
    logic num_ready;
    num_t num       = '0;
    logic chr_valid;
    logic chr_ready = 1'b0;
    chr_t chr;

    bit            calm = 1'b0;
    chr_scoreboard sb = new();
    int            stuck_cycles = 0;

    binary_to_decimal_ascii_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr       (chr)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: stall at random except during the calm stretch.
    always @(posedge clk)
    begin
        chr_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Take characters, check them, and watch for a hung core.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chr_valid && chr_ready)
                sb.check_char(chr);
            if ((chr_valid && chr_ready) || (num_valid && num_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("binary_to_decimal_ascii_core: mismatch");
                $finish;
            end
        end
    end

    task automatic send_number(input logic f, input logic [VALUE_W-1:0] v);
        num_t n;
        n.func = f;
        n.value = v;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            num_valid <= 1'b0;
            @(posedge clk);
        end
        num_valid <= 1'b1;
        num <= n;
        // Hold the item until the core takes it.
        do
            @(posedge clk);
        while (!num_ready);
        sb.note_number(n);
    endtask

    task automatic send_random_number();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        logic               f;
        int                 shape;
        f = 1'($urandom_range(1));
        shape = $urandom_range(4);
        p = 1;
        case (shape)
            0: v = $urandom();
            1: v = $urandom_range(999);
            2:
            begin
                // Decade boundaries, where the digit count changes.
                repeat ($urandom_range(9)) p = p * 10;
                v = p - $urandom_range(1);
            end
            3:
            begin
                if ($urandom_range(1))
                    v = 32'h8000_0000 + $urandom_range(15);
                else
                    v = 32'h7FFF_FFFF - $urandom_range(15);
            end
            default: v = '0 - $urandom_range(99);
        endcase
        send_number(f, v);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_number(FMT_UNSIGNED, 32'd0);
        send_number(FMT_SIGNED,   32'd0);
        send_number(FMT_SIGNED,   32'h8000_0000);
        send_number(FMT_UNSIGNED, 32'h8000_0000);
        send_number(FMT_SIGNED,   32'h8000_0001);
        send_number(FMT_SIGNED,   32'hFFFF_FFFF);
        send_number(FMT_UNSIGNED, 32'hFFFF_FFFF);
        send_number(FMT_SIGNED,   32'h7FFF_FFFF);
        send_number(FMT_UNSIGNED, 32'h7FFF_FFFF);
        send_number(FMT_UNSIGNED, 32'd1);
        send_number(FMT_SIGNED,   32'd9);
        send_number(FMT_UNSIGNED, 32'd10);
        send_number(FMT_SIGNED,   32'hFFFF_FFF6);
        send_number(FMT_UNSIGNED, 32'd99);
        send_number(FMT_UNSIGNED, 32'd100);
        send_number(FMT_SIGNED,   32'd999_999_999);
        send_number(FMT_UNSIGNED, 32'd1_000_000_000);
        send_number(FMT_SIGNED,   32'hC465_3600);
        send_number(FMT_UNSIGNED, 32'hAAAA_AAAA);
        send_number(FMT_SIGNED,   32'h5555_5555);

        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            calm = (i >= 120 && i < 180);
            send_random_number();
        end
        calm = 1'b0;
        num_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d characters never arrived", $time, sb.pending());
        end
        $display("Covered %0d numbers (%0d printed negative) and %0d characters, %0d errors.",
                 sb.numbers_taken, sb.negatives_taken, sb.chars_checked, sb.errors);
        if (sb.errors == 0)
            $display("binary_to_decimal_ascii_core: match");
        else
            $display("binary_to_decimal_ascii_core: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/b2da_pkg.sv
rtl/b2da_dd_stage.sv
rtl/b2da_serial.sv
rtl/binary_to_decimal_ascii_core.sv
sim/tb_top.sv
